FILE: hw/rtl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants
// request kinds, access modes and fixed field widths of the channel 0 scheduler
// ----------------------------------------------------------------------------
package pit_pkg;

	typedef enum logic [1:0] {
		REQ_CONTROL = 2'd0,
		REQ_DATA    = 2'd1,
		REQ_POLL    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		AM_UNSET  = 2'd0,
		AM_LOW    = 2'd1,
		AM_HIGH   = 2'd2,
		AM_LOHI   = 2'd3
	} access_mode_t;

	localparam int unsigned NS_PER_SEC = 1000000000;
	localparam int unsigned NS_W       = 30;  // bits of one second in ns
	localparam int unsigned TIME_W     = 64;
	localparam int unsigned DIV_W      = 17;
	localparam int unsigned GEN_W      = 32;

endpackage

FILE: hw/rtl/pit_channel0_tick_scheduler.sv
// ----------------------------------------------------------------------------
// pit_channel0_tick_scheduler
// channel 0 of an interval timer with a tick scheduler driven by elapsed time
// ----------------------------------------------------------------------------
// Control and data writes, and polls that restart the epoch, go straight
// to S_DONE. A poll that counts ticks runs one shared restoring divider (one
// quotient bit a cycle) and one shift-add multiplier (one bit of INPUT_CLOCK_HZ
// a cycle): elapsed time is split into whole seconds and a remainder, both are
// scaled by INPUT_CLOCK_HZ, and the clock count is divided by the divisor.
// One item is worked at a time; the next is taken once the result sits in
// the output register.
module pit_channel0_tick_scheduler #(
	parameter int unsigned INPUT_CLOCK_HZ  = 1193182,
	parameter int unsigned DEFAULT_DIVISOR = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // data_byte[7:0], elapsed_ns[71:8]
	input  logic [1:0]   s_tuser,   // req_type[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// accepted[0], reload_divisor[17:1], generation[49:18], due_ticks[113:50],
	// first_due[177:114], epoch_ns[241:178], zero[247:242]
	output logic [247:0] m_tdata
);

	localparam int unsigned HZW = $clog2(INPUT_CLOCK_HZ + 1);
	localparam logic [HZW-1:0] HZ_BITS = HZW'(INPUT_CLOCK_HZ);
	localparam logic [pit_pkg::DIV_W-1:0] DEF_DIV = pit_pkg::DIV_W'(DEFAULT_DIVISOR);
	localparam logic [pit_pkg::NS_W-1:0] NS_SEC = pit_pkg::NS_W'(pit_pkg::NS_PER_SEC);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV_SEC, S_MUL_Q, S_MUL_R, S_DIV_FRAC, S_ADD, S_DIV_TICK, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0]  access_mode_q;
	logic        awaiting_low_q;
	logic [7:0]  pending_low_q;
	logic [pit_pkg::DIV_W-1:0] divisor_q;
	logic [pit_pkg::GEN_W-1:0] gen_q;
	logic        started_q;
	logic [pit_pkg::GEN_W-1:0] sched_gen_q;
	logic [63:0] epoch_q;
	logic [63:0] emitted_q;

	logic        ok_q;
	logic        cmp_q;
	logic [63:0] due_q, first_q, epoch_out_q;

	logic [63:0] dvd_q;
	logic [pit_pkg::NS_W-1:0] rem_q, dvs_q, r_q;
	logic [63:0] acc_q, mx_q, clk_q;
	logic [HZW-1:0] hz_q;
	logic [6:0]  cnt_q;

	logic [1:0]  req;
	logic [7:0]  data_byte;
	logic [63:0] elapsed_ns;
	assign req        = s_tuser;
	assign data_byte  = s_tdata[7:0];
	assign elapsed_ns = s_tdata[71:8];

	assign s_tready = (state_q == S_IDLE);

	// divider step
	logic [pit_pkg::NS_W:0] rem_sh, rem_sub;
	logic ge;
	assign rem_sh  = {rem_q, dvd_q[63]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	logic [15:0] reload;
	assign reload = (divisor_q == DEF_DIV) ? 16'd0 : divisor_q[15:0];

	function automatic logic [pit_pkg::DIV_W-1:0] to_div(input logic [15:0] v,
			input logic [pit_pkg::DIV_W-1:0] d);
		to_div = (v == 16'd0) ? d : {1'b0, v};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			access_mode_q  <= pit_pkg::AM_UNSET;
			awaiting_low_q <= 1'b1;
			pending_low_q  <= 8'd0;
			divisor_q      <= DEF_DIV;
			gen_q          <= pit_pkg::GEN_W'(1);
			started_q      <= 1'b0;
			sched_gen_q    <= '0;
			epoch_q        <= '0;
			emitted_q      <= '0;
			m_tvalid       <= 1'b0;
			m_tdata        <= '0;
			cnt_q          <= '0;
			ok_q           <= 1'b0;
			cmp_q          <= 1'b0;
			due_q          <= '0;
			first_q        <= '0;
			epoch_out_q    <= '0;
			dvd_q          <= '0;
			rem_q          <= '0;
			dvs_q          <= '0;
			r_q            <= '0;
			acc_q          <= '0;
			mx_q           <= '0;
			clk_q          <= '0;
			hz_q           <= '0;
		end else begin
			// a new result loaded in S_DONE takes the place of the one leaving
			if (m_tvalid && m_tready && !(state_q == S_DONE && !cmp_q)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ok_q        <= 1'b0;
						cmp_q       <= 1'b0;
						due_q       <= '0;
						first_q     <= '0;
						epoch_out_q <= '0;
						state_q     <= S_DONE;
						unique case (req)
							pit_pkg::REQ_CONTROL: begin
								if (data_byte[7:6] == 2'd0 && data_byte[5:4] != pit_pkg::AM_UNSET) begin
									access_mode_q  <= data_byte[5:4];
									awaiting_low_q <= 1'b1;
									ok_q           <= 1'b1;
								end
							end
							pit_pkg::REQ_DATA: begin
								unique case (access_mode_q)
									pit_pkg::AM_LOW: begin
										divisor_q <= to_div({reload[15:8], data_byte}, DEF_DIV);
										gen_q     <= gen_q + pit_pkg::GEN_W'(1);
										ok_q      <= 1'b1;
									end
									pit_pkg::AM_HIGH: begin
										divisor_q <= to_div({data_byte, reload[7:0]}, DEF_DIV);
										gen_q     <= gen_q + pit_pkg::GEN_W'(1);
										ok_q      <= 1'b1;
									end
									pit_pkg::AM_LOHI: begin
										if (awaiting_low_q) begin
											pending_low_q  <= data_byte;
											awaiting_low_q <= 1'b0;
										end else begin
											awaiting_low_q <= 1'b1;
											divisor_q <= to_div({data_byte, pending_low_q}, DEF_DIV);
											gen_q     <= gen_q + pit_pkg::GEN_W'(1);
										end
										ok_q <= 1'b1;
									end
									default: ;
								endcase
							end
							pit_pkg::REQ_POLL: begin
								ok_q <= 1'b1;
								if (!started_q || sched_gen_q != gen_q) begin
									started_q   <= 1'b1;
									sched_gen_q <= gen_q;
									epoch_q     <= elapsed_ns;
									emitted_q   <= '0;
								end else if (elapsed_ns < epoch_q) begin
									epoch_q   <= elapsed_ns;
									emitted_q <= '0;
								end else begin
									dvd_q   <= elapsed_ns - epoch_q;
									rem_q   <= '0;
									dvs_q   <= NS_SEC;
									cnt_q   <= 7'd63;
									state_q <= S_DIV_SEC;
								end
							end
							default: ;
						endcase
					end
				end
				S_DIV_SEC, S_DIV_FRAC, S_DIV_TICK: begin
					rem_q <= ge ? rem_sub[pit_pkg::NS_W-1:0] : rem_sh[pit_pkg::NS_W-1:0];
					dvd_q <= {dvd_q[62:0], ge};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						priority if (state_q == S_DIV_SEC) begin
							// whole seconds times clock rate first
							mx_q    <= {dvd_q[62:0], ge};
							r_q     <= ge ? rem_sub[pit_pkg::NS_W-1:0] : rem_sh[pit_pkg::NS_W-1:0];
							acc_q   <= '0;
							hz_q    <= HZ_BITS;
							cnt_q   <= 7'(HZW - 1);
							state_q <= S_MUL_Q;
						end else if (state_q == S_DIV_FRAC) begin
							state_q <= S_ADD;
						end else begin
							cmp_q   <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_MUL_Q, S_MUL_R: begin
					acc_q <= {acc_q[62:0], 1'b0} + (hz_q[HZW-1] ? mx_q : 64'd0);
					hz_q  <= {hz_q[HZW-2:0], 1'b0};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						if (state_q == S_MUL_Q) begin
							clk_q   <= {acc_q[62:0], 1'b0} + (hz_q[HZW-1] ? mx_q : 64'd0);
							mx_q    <= {{(64 - pit_pkg::NS_W){1'b0}}, r_q};
							acc_q   <= '0;
							hz_q    <= HZ_BITS;
							cnt_q   <= 7'(HZW - 1);
							state_q <= S_MUL_R;
						end else begin
							dvd_q   <= {acc_q[62:0], 1'b0} + (hz_q[HZW-1] ? mx_q : 64'd0);
							rem_q   <= '0;
							cnt_q   <= 7'd63;
							state_q <= S_DIV_FRAC;
						end
					end
				end
				S_ADD: begin
					dvd_q   <= clk_q + dvd_q;
					rem_q   <= '0;
					dvs_q   <= {{(pit_pkg::NS_W - pit_pkg::DIV_W){1'b0}}, divisor_q};
					cnt_q   <= 7'd63;
					state_q <= S_DIV_TICK;
				end
				S_DONE: begin
					// tick count sits in dvd_q after the last division
					if (cmp_q) begin
						cmp_q <= 1'b0;
						if (dvd_q > emitted_q) begin
							due_q       <= dvd_q - emitted_q;
							first_q     <= emitted_q + 64'd1;
							epoch_out_q <= epoch_q;
							emitted_q   <= dvd_q;
						end
					end else if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {6'd0, epoch_out_q, first_q, due_q, gen_q, divisor_q, ok_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker: port assertions
// watches the result stream of the channel 0 scheduler
// ----------------------------------------------------------------------------
module pit_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [247:0] m_tdata
);

	// stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// divisor never reads as zero
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[17:1] != 17'd0)
		else $error("zero divisor reported");

	// no due ticks means no ordinal
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[113:50] == 64'd0 |-> m_tdata[177:114] == 64'd0)
		else $error("ordinal without due ticks");

	// due ticks only come with an accepted item
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[113:50] != 64'd0 |-> m_tdata[0])
		else $error("due ticks on rejected item");

endmodule

bind pit_channel0_tick_scheduler pit_checker u_pit_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/sv/tb_pit_channel0_tick_scheduler.sv
// ----------------------------------------------------------------------------
// tb_pit_channel0_tick_scheduler
// random and directed port writes and time polls against a behavioral predictor
// of the channel 0 timer and its tick scheduler, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_pit_channel0_tick_scheduler;

	localparam longint unsigned CLK_HZ   = 1193182;
	localparam int unsigned     DIV_DFLT = 65536;
	localparam longint unsigned CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [5:0]  pad;
		logic [63:0] epoch_ns;
		logic [63:0] first_ord;
		logic [63:0] due;
		logic [31:0] gen;
		logic [16:0] divisor;
		logic        ok;
	} tick_result_t;

	class tick_scoreboard;
		pit_pkg::access_mode_t mode;
		bit               want_low;
		bit [7:0]         low_latch;
		bit [16:0]        divisor;
		bit [31:0]        gen;
		bit               started;
		bit [31:0]        sched_gen;
		bit [63:0]        epoch;
		bit [63:0]        emitted;
		tick_result_t     pending_q[$];
		int               errors;

		function void clear();
			mode = pit_pkg::AM_UNSET; want_low = 1; low_latch = 0;
			divisor = 17'(DIV_DFLT);
			gen = 1; started = 0; sched_gen = 0; epoch = 0; emitted = 0;
			errors = 0;
		endfunction

		function void load(bit [15:0] v);
			divisor = (v == 0) ? 17'(DIV_DFLT) : {1'b0, v};
			gen = gen + 1;
		endfunction

		function bit [63:0] ticks_in(bit [63:0] ns);
			bit [63:0] clocks;
			clocks = (ns / 64'd1000000000) * CLK_HZ
				+ ((ns % 64'd1000000000) * CLK_HZ) / 64'd1000000000;
			return clocks / {47'd0, divisor};
		endfunction

		function void note_input(pit_pkg::req_t kind, bit [7:0] b, bit [63:0] ns);
			tick_result_t r;
			bit [15:0] reload;
			bit [63:0] t;
			r = '0;
			reload = (divisor == 17'(DIV_DFLT)) ? 16'd0 : divisor[15:0];
			case (kind)
				pit_pkg::REQ_CONTROL: begin
					if (b[7:6] == 0 && b[5:4] != pit_pkg::AM_UNSET) begin
						mode = pit_pkg::access_mode_t'(b[5:4]);
						want_low = 1;
						r.ok = 1;
					end
				end
				pit_pkg::REQ_DATA: begin
					case (mode)
						pit_pkg::AM_LOW: begin
							load({reload[15:8], b}); r.ok = 1;
						end
						pit_pkg::AM_HIGH: begin
							load({b, reload[7:0]}); r.ok = 1;
						end
						pit_pkg::AM_LOHI: begin
							if (want_low) begin
								low_latch = b; want_low = 0;
							end else begin
								want_low = 1; load({b, low_latch});
							end
							r.ok = 1;
						end
						default: ;
					endcase
				end
				pit_pkg::REQ_POLL: begin
					r.ok = 1;
					if (!started || sched_gen != gen) begin
						started = 1; sched_gen = gen; epoch = ns; emitted = 0;
					end else if (ns < epoch) begin
						epoch = ns; emitted = 0;
					end else begin
						t = ticks_in(ns - epoch);
						if (t > emitted) begin
							r.due = t - emitted;
							r.first_ord = emitted + 1;
							r.epoch_ns = epoch;
							emitted = t;
						end
					end
				end
				default: ;
			endcase
			r.divisor = divisor;
			r.gen = gen;
			pending_q.push_back(r);
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t exp;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp = pending_q.pop_front();
			if (got.ok !== exp.ok)
				$display("%0t: accepted exp %0d got %0d", $time, exp.ok, got.ok);
			if (got.divisor !== exp.divisor)
				$display("%0t: divisor exp %0d got %0d", $time, exp.divisor, got.divisor);
			if (got.gen !== exp.gen)
				$display("%0t: generation exp %0d got %0d", $time, exp.gen, got.gen);
			if (got.due !== exp.due)
				$display("%0t: due_ticks exp %0d got %0d", $time, exp.due, got.due);
			if (got.first_ord !== exp.first_ord)
				$display("%0t: first_tick exp %0d got %0d", $time, exp.first_ord,
					got.first_ord);
			if (got.epoch_ns !== exp.epoch_ns)
				$display("%0t: epoch_ns exp %0d got %0d", $time, exp.epoch_ns, got.epoch_ns);
			if (got.pad !== 0)
				$display("%0t: pad bits exp 0 got %h", $time, got.pad);
			if (got !== exp)
				errors++;
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;   // data_byte[7:0], elapsed_ns[71:8]
	logic [1:0]   s_tuser;   // req_type[1:0]
	logic         m_tvalid;
	logic         m_tready;
	logic [247:0] m_tdata;   // accepted, divisor, generation, due, first, epoch, zero

	tick_scoreboard board;
	longint unsigned cycles;
	bit     hold_rx;
	bit [63:0] clock_ns;

	pit_channel0_tick_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// tvalid stays high into the next transfer when there is no gap
	task automatic send(pit_pkg::req_t kind, bit [7:0] b, bit [63:0] ns);
		int g;
		g = gap_len();
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {ns, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_input(kind, b, ns);
	endtask

	// polls mostly move forward by up to 200 ms, sometimes jump or go back
	function bit [63:0] next_ns();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) clock_ns = clock_ns + 64'($urandom_range(0, 200000000));
		else if (p < 80) clock_ns = clock_ns - 64'($urandom_range(0, 1000000));
		else if (p < 88) clock_ns = {$urandom, $urandom};
		else if (p < 94) clock_ns = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
		else clock_ns = clock_ns + {$urandom_range(0, 255), $urandom};
		return clock_ns;
	endfunction

	task automatic send_random();
		int p;
		bit [7:0] b;
		p = $urandom_range(0, 99);
		b = 8'($urandom_range(0, 255));
		if (p < 6) begin
			if ($urandom_range(0, 3) != 0) b[7:6] = 2'd0;
			send(pit_pkg::REQ_CONTROL, b, {$urandom, $urandom});
		end else if (p < 18) begin
			send(pit_pkg::REQ_DATA, b, {$urandom, $urandom});
		end else if (p < 96) begin
			send(pit_pkg::REQ_POLL, b, next_ns());
		end else begin
			send(pit_pkg::REQ_NONE, b, {$urandom, $urandom});
		end
	endtask

	// receiver: random ready, plus one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(tick_result_t'(m_tdata));
			m_tready <= hold_rx ? 1'b0 : (gap_len() == 0);
		end else begin
			m_tready <= 1'b0;
		end
	end

	initial begin
		hold_rx = 1'b0;
		repeat (800) @(posedge clk);
		hold_rx = 1'b1;
		repeat (3000) @(posedge clk);
		hold_rx = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int wait_n;
		board = new();
		board.clear();
		clock_ns = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = pit_pkg::REQ_NONE;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// writes with no mode set, bad channel, mode zero, then a none request
		send(pit_pkg::REQ_DATA, 8'h12, 0);
		send(pit_pkg::REQ_CONTROL, 8'h40, 0);
		send(pit_pkg::REQ_CONTROL, 8'h00, 0);
		send(pit_pkg::REQ_NONE, 8'hFF, '1);
		// first poll starts epoch, then ticks at default divisor and a step back
		send(pit_pkg::REQ_POLL, 8'h00, 64'd0);
		send(pit_pkg::REQ_POLL, 8'hFF, 64'd1000000000);
		send(pit_pkg::REQ_POLL, 8'h00, 64'd500);
		send(pit_pkg::REQ_POLL, 8'h00, '1);
		// low byte, high byte, lo/hi modes, and polls after the lo/hi loads
		send(pit_pkg::REQ_CONTROL, 8'h10, 0);
		send(pit_pkg::REQ_DATA, 8'h02, 0);
		send(pit_pkg::REQ_CONTROL, 8'h20, 0);
		send(pit_pkg::REQ_DATA, 8'hFF, 0);
		send(pit_pkg::REQ_CONTROL, 8'h30, 0);
		send(pit_pkg::REQ_DATA, 8'h00, 0);
		send(pit_pkg::REQ_DATA, 8'h00, 0);
		send(pit_pkg::REQ_POLL, 8'h00, 64'd100);
		send(pit_pkg::REQ_POLL, 8'h00, 64'd100000000);
		send(pit_pkg::REQ_CONTROL, 8'h30, 0);
		send(pit_pkg::REQ_DATA, 8'h02, 0);
		send(pit_pkg::REQ_CONTROL, 8'h3E, 0);
		send(pit_pkg::REQ_DATA, 8'h01, 0);
		send(pit_pkg::REQ_DATA, 8'h00, 0);
		send(pit_pkg::REQ_POLL, 8'h00, 64'd0);
		send(pit_pkg::REQ_POLL, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
		clock_ns = 0;

		repeat (2000) send_random();
		s_tvalid <= 1'b0;

		while (board.pending_q.size() != 0) @(posedge clk);
		wait_n = 0;
		while (wait_n < 400) begin
			@(posedge clk);
			wait_n++;
		end
		if (board.errors == 0 && board.pending_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
